// ===== hw/rtl/lic_pkg.sv =====
// ----------------------------------------------------------------------------
// lic_pkg
// Shared types and codes of the level interrupt controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lic_pkg;

   localparam int NUM_LINES_DEFAULT = 32;
   localparam int MASK_WIDTH        = 32;
   localparam int OFFSET_WIDTH      = 12;
   localparam int LINE_WIDTH        = 5;
   localparam int DATA_WIDTH        = 6;

   localparam logic [1:0] OP_LEVEL = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;

   localparam logic [OFFSET_WIDTH-1:0] OFS_STATUS      = 12'h000;
   localparam logic [OFFSET_WIDTH-1:0] OFS_NUMBER      = 12'h004;
   localparam logic [OFFSET_WIDTH-1:0] OFS_DISABLE_ALL = 12'h008;
   localparam logic [OFFSET_WIDTH-1:0] OFS_DISABLE     = 12'h00c;
   localparam logic [OFFSET_WIDTH-1:0] OFS_ENABLE      = 12'h010;

   typedef struct packed {
      logic                    line_level;
      logic [LINE_WIDTH-1:0]   line;
      logic [OFFSET_WIDTH-1:0] register_offset;
      logic [1:0]              operation;
   } item_type;

   typedef struct packed {
      logic                  bad_access;
      logic                  fiq_out;
      logic                  irq_out;
      logic [DATA_WIDTH-1:0] read_data;
   } result_type;

endpackage

// ===== hw/rtl/lic_prio.sv =====
// ----------------------------------------------------------------------------
// lic_prio
// Priority encoder: number of the lowest set pending line, zero if none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lic_prio #(
   parameter int NUM_LINES = lic_pkg::NUM_LINES_DEFAULT
) (
   input  logic [NUM_LINES-1:0]            pending,
   output logic [lic_pkg::DATA_WIDTH-1:0]  lowest
);
   import lic_pkg::*;

   always_comb begin
      lowest = '0;
      for (int i = NUM_LINES - 1; i >= 0; i--) begin
         if (pending[i]) begin
            lowest = DATA_WIDTH'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/lic_core.sv =====
// ----------------------------------------------------------------------------
// lic_core
// Line state, enable mask and pending count; decodes one item per cycle while
// accept is high and forms its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lic_core #(
   parameter int NUM_LINES = lic_pkg::NUM_LINES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  lic_pkg::item_type              item,
   input  logic [lic_pkg::MASK_WIDTH-1:0] fiq_mask,
   output lic_pkg::result_type            result
);
   import lic_pkg::*;

   logic [NUM_LINES-1:0]  levels_ff;
   logic [NUM_LINES-1:0]  levels_in;
   logic [NUM_LINES-1:0]  enabled_ff;
   logic [NUM_LINES-1:0]  enabled_in;
   logic [DATA_WIDTH-1:0] pending_ff;
   logic [DATA_WIDTH-1:0] pending_in;
   logic [DATA_WIDTH-1:0] lowest;
   logic [NUM_LINES-1:0]  line_mask;
   logic                  line_hit;
   logic                  level_bit;
   logic                  enable_bit;

   lic_prio #(
      .NUM_LINES (NUM_LINES)
   ) u_prio (
      .pending (levels_ff & enabled_ff),
      .lowest  (lowest)
   );

   assign line_hit   = {1'b0, item.line} < DATA_WIDTH'(NUM_LINES);
   assign line_mask  = line_hit ? (NUM_LINES'(1) << item.line) : '0;
   assign level_bit  = |(levels_ff & line_mask);
   assign enable_bit = |(enabled_ff & line_mask);

   always_comb begin
      levels_in         = levels_ff;
      enabled_in        = enabled_ff;
      pending_in        = pending_ff;
      result.read_data  = '0;
      result.bad_access = 1'b0;
      case (item.operation)
         OP_LEVEL: begin
            if (item.line_level && !level_bit) begin
               levels_in = levels_ff | line_mask;
               if (enable_bit) begin
                  pending_in = pending_ff + DATA_WIDTH'(1);
               end
            end else if (!item.line_level && level_bit) begin
               levels_in = levels_ff & ~line_mask;
               if (enable_bit) begin
                  pending_in = pending_ff - DATA_WIDTH'(1);
               end
            end
         end
         OP_READ: begin
            case (item.register_offset)
               OFS_STATUS: result.read_data = pending_ff;
               OFS_NUMBER: result.read_data = lowest;
               default:    result.bad_access = 1'b1;
            endcase
         end
         OP_WRITE: begin
            case (item.register_offset)
               OFS_DISABLE_ALL: begin
                  levels_in  = '0;
                  pending_in = '0;
               end
               OFS_DISABLE: begin
                  if (enable_bit) begin
                     enabled_in = enabled_ff & ~line_mask;
                     if (level_bit) begin
                        pending_in = pending_ff - DATA_WIDTH'(1);
                     end
                  end
               end
               OFS_ENABLE: begin
                  if (!enable_bit) begin
                     enabled_in = enabled_ff | line_mask;
                     if (level_bit) begin
                        pending_in = pending_ff + DATA_WIDTH'(1);
                     end
                  end
               end
               default: result.bad_access = 1'b1;
            endcase
         end
         default: begin
         end
      endcase
      result.irq_out = |(levels_in & enabled_in);
      result.fiq_out = |(levels_in & fiq_mask[NUM_LINES-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff  <= '0;
         enabled_ff <= '0;
         pending_ff <= '0;
      end else if (accept) begin
         levels_ff  <= levels_in;
         enabled_ff <= enabled_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== hw/rtl/level_interrupt_controller.sv =====
// ----------------------------------------------------------------------------
// level_interrupt_controller
// Level-sensitive interrupt controller for up to 32 lines.
//
// The req channel carries one item per handshake: a line level change, a bus
// read or a bus write, selected by req_tuser. Every item yields exactly one
// item on the rsp channel with the read data, the IRQ and FIQ levels after
// the item, and a bad access flag for unsupported offsets.
// rsp_tvalid rises in the cycle after req acceptance; throughput is one item
// per cycle while rsp_tready is high, set by the single pass through the line
// state update and the 32-line priority encoder. The result register frees as
// it is taken, so req_tready stays high while rsp_tready is high.
// When the receiver stalls, the result holds in the output register and
// req_tready drops until it is taken.
// Reset clears line levels, the enable mask, the pending count, the FIQ mask
// and the output valid. The FIQ mask is loaded through csr_we / csr_wdata;
// the user must do so only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module level_interrupt_controller #(
   parameter int NUM_LINES = lic_pkg::NUM_LINES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [11:0] register_offset, [16:12] line, [17] line_level, [23:18] zero
   input  logic [23:0]                    req_tdata,
   // [1:0] operation
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [5:0] read_data, [6] irq_out, [7] fiq_out
   output logic [7:0]                     rsp_tdata,
   // [0] bad_access
   output logic                           rsp_tuser,
   input  logic                           csr_we,
   input  logic [lic_pkg::MASK_WIDTH-1:0] csr_wdata
);
   import lic_pkg::*;

   logic                  accept;
   item_type              item;
   result_type            result;
   result_type            rsp_ff;
   logic                  rsp_valid_ff;
   logic [MASK_WIDTH-1:0] fiq_mask_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign item.operation       = req_tuser;
   assign item.register_offset = req_tdata[11:0];
   assign item.line            = req_tdata[16:12];
   assign item.line_level      = req_tdata[17];

   lic_core #(
      .NUM_LINES (NUM_LINES)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .item     (item),
      .fiq_mask (fiq_mask_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fiq_mask_ff <= '0;
      end else if (csr_we) begin
         fiq_mask_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.fiq_out, rsp_ff.irq_out, rsp_ff.read_data};
   assign rsp_tuser  = rsp_ff.bad_access;

endmodule

// ===== hw/rtl/lic_checker.sv =====
// ----------------------------------------------------------------------------
// lic_checker
// Port-level checks of the level interrupt controller, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lic_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted item gave no result");

   a_bad_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[5:0] == 6'd0)
      else $error("bad access carries read data");

   a_data_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5:0] <= 6'd32)
      else $error("read data out of range");

endmodule

bind level_interrupt_controller lic_checker u_lic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the level interrupt controller. A local predictor
// tracks line levels, the IRQ enable mask, the pending count and the FIQ mask,
// and every response item is compared field by field with the oldest
// prediction. Directed items cover the register offsets and corner cases,
// then random traffic runs under several FIQ mask settings with bursty
// request timing, random response stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   import lic_pkg::*;

   localparam logic [1:0]              OP_UNUSED   = 2'd3;
   localparam logic [OFFSET_WIDTH-1:0] OFS_BAD     = 12'hfff;
   localparam int                      ITEMS_PER_MASK = 250;
   localparam int                      HOLD_CYCLES = 300;
   localparam int                      STALL_LIMIT = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [MASK_WIDTH-1:0] csr_wdata  = '0;

   logic [MASK_WIDTH-1:0] line_levels_now;
   logic [MASK_WIDTH-1:0] irq_enables_now;
   logic [MASK_WIDTH-1:0] fiq_mask_now;
   logic [DATA_WIDTH-1:0] pending_now;

   result_type expected_results[$];

   int  sent_count    = 0;
   int  checked_count = 0;
   int  failure_count = 0;
   int  mask_settings = 0;
   int  peak_pending  = 0;
   int  burst_left    = 0;
   int  idle_cycles   = 0;
   bit  hold_request  = 1'b0;
   bit  hold_active   = 1'b0;

   level_interrupt_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic item_type make_item(logic [1:0] op, logic [OFFSET_WIDTH-1:0] ofs,
                                          logic [LINE_WIDTH-1:0] ln, logic lvl);
      item_type it;
      it.operation       = op;
      it.register_offset = ofs;
      it.line            = ln;
      it.line_level      = lvl;
      return it;
   endfunction

   function automatic result_type predict_interrupt_result(item_type it);
      result_type            r;
      logic [MASK_WIDTH-1:0] bitm;
      logic [MASK_WIDTH-1:0] pend;
      logic                  found;
      r     = '0;
      found = 1'b0;
      bitm  = 32'd1 << it.line;
      case (it.operation)
         OP_LEVEL: begin
            if (it.line_level) begin
               if ((line_levels_now & bitm) == 0) begin
                  if ((irq_enables_now & bitm) != 0) pending_now = pending_now + 1'b1;
                  line_levels_now = line_levels_now | bitm;
               end
            end else if ((line_levels_now & bitm) != 0) begin
               if ((irq_enables_now & bitm) != 0) pending_now = pending_now - 1'b1;
               line_levels_now = line_levels_now & ~bitm;
            end
         end
         OP_READ: begin
            if (it.register_offset == OFS_STATUS) begin
               r.read_data = pending_now;
            end else if (it.register_offset == OFS_NUMBER) begin
               pend = line_levels_now & irq_enables_now;
               for (int i = 0; i < MASK_WIDTH; i++) begin
                  if (!found && pend[i]) begin
                     r.read_data = DATA_WIDTH'(i);
                     found       = 1'b1;
                  end
               end
            end else begin
               r.bad_access = 1'b1;
            end
         end
         OP_WRITE: begin
            if (it.register_offset == OFS_DISABLE_ALL) begin
               pending_now     = '0;
               line_levels_now = '0;
            end else if (it.register_offset == OFS_DISABLE) begin
               if ((irq_enables_now & bitm) != 0) begin
                  if ((line_levels_now & bitm) != 0) pending_now = pending_now - 1'b1;
                  irq_enables_now = irq_enables_now & ~bitm;
               end
            end else if (it.register_offset == OFS_ENABLE) begin
               if ((irq_enables_now & bitm) == 0) begin
                  irq_enables_now = irq_enables_now | bitm;
                  if ((line_levels_now & bitm) != 0) pending_now = pending_now + 1'b1;
               end
            end else begin
               r.bad_access = 1'b1;
            end
         end
         default: ;
      endcase
      r.irq_out = |(line_levels_now & irq_enables_now);
      r.fiq_out = |(line_levels_now & fiq_mask_now);
      return r;
   endfunction

   function automatic item_type random_item();
      item_type it;
      int       pick;
      int       sub;
      pick = $urandom_range(0, 99);
      sub  = $urandom_range(0, 99);
      it   = make_item(OP_LEVEL, OFFSET_WIDTH'($urandom), LINE_WIDTH'($urandom),
                       1'($urandom));
      if (pick < 40) begin
         it.operation = OP_LEVEL;
      end else if (pick < 65) begin
         it.operation       = OP_READ;
         it.register_offset = (sub < 50) ? OFS_STATUS : OFS_NUMBER;
      end else if (pick < 90) begin
         it.operation = OP_WRITE;
         if (sub < 3) it.register_offset = OFS_DISABLE_ALL;
         else if (sub < 40) it.register_offset = OFS_DISABLE;
         else it.register_offset = OFS_ENABLE;
      end else begin
         it.operation = 2'($urandom_range(1, 3));
      end
      return it;
   endfunction

   // Send one item in bursts with random gaps; valid stays high between items of a burst.
   task automatic send_item(item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left = burst_left - 1;
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, it.line_level, it.line, it.register_offset};
      req_tuser  <= it.operation;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_interrupt_result(it));
      if (int'(pending_now) > peak_pending) peak_pending = int'(pending_now);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_fiq_mask(logic [MASK_WIDTH-1:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we       <= 1'b0;
      fiq_mask_now  = value;
      mask_settings++;
   endtask

   task automatic test_directed();
      send_item(make_item(OP_READ,  OFS_STATUS,  5'd0,  1'b0));
      send_item(make_item(OP_READ,  OFS_NUMBER,  5'd0,  1'b0));
      send_item(make_item(OP_WRITE, OFS_ENABLE,  5'd0,  1'b0));
      send_item(make_item(OP_WRITE, OFS_ENABLE,  5'd31, 1'b1));
      send_item(make_item(OP_LEVEL, OFS_BAD,     5'd31, 1'b1));
      send_item(make_item(OP_LEVEL, OFS_STATUS,  5'd0,  1'b1));
      send_item(make_item(OP_READ,  OFS_STATUS,  5'd0,  1'b0));
      send_item(make_item(OP_READ,  OFS_NUMBER,  5'd0,  1'b0));
      send_item(make_item(OP_WRITE, OFS_DISABLE, 5'd0,  1'b0));
      send_item(make_item(OP_READ,  OFS_NUMBER,  5'd0,  1'b0));
      send_item(make_item(OP_LEVEL, OFS_STATUS,  5'd31, 1'b1));
      send_item(make_item(OP_WRITE, OFS_ENABLE,  5'd31, 1'b0));
      send_item(make_item(OP_WRITE, OFS_DISABLE, 5'd0,  1'b0));
      send_item(make_item(OP_READ,  OFS_BAD,     5'd31, 1'b1));
      send_item(make_item(OP_WRITE, OFS_STATUS,  5'd31, 1'b0));
      send_item(make_item(OP_READ,  OFS_ENABLE,  5'd0,  1'b0));
      send_item(make_item(OP_UNUSED, OFS_BAD,    5'd31, 1'b1));
      send_item(make_item(OP_WRITE, OFS_DISABLE_ALL, 5'd0, 1'b0));
      send_item(make_item(OP_READ,  OFS_STATUS,  5'd0,  1'b0));
      send_item(make_item(OP_READ,  OFS_NUMBER,  5'd0,  1'b0));
      send_item(make_item(OP_LEVEL, OFS_STATUS,  5'd0,  1'b0));
      send_item(make_item(OP_LEVEL, OFS_STATUS,  5'd5,  1'b1));
      send_item(make_item(OP_READ,  OFS_STATUS,  5'd0,  1'b0));
   endtask

   task automatic test_all_lines_pending();
      for (int i = 0; i < MASK_WIDTH; i++) begin
         send_item(make_item(OP_WRITE, OFS_ENABLE, LINE_WIDTH'(i), 1'b0));
      end
      for (int i = MASK_WIDTH - 1; i >= 0; i--) begin
         send_item(make_item(OP_LEVEL, OFS_STATUS, LINE_WIDTH'(i), 1'b1));
      end
      send_item(make_item(OP_READ,  OFS_STATUS, 5'd0, 1'b0));
      send_item(make_item(OP_READ,  OFS_NUMBER, 5'd0, 1'b0));
      send_item(make_item(OP_LEVEL, OFS_STATUS, 5'd0, 1'b0));
      send_item(make_item(OP_READ,  OFS_NUMBER, 5'd0, 1'b0));
      send_item(make_item(OP_READ,  OFS_STATUS, 5'd0, 1'b0));
   endtask

   task automatic test_fiq_mask_phase(logic [MASK_WIDTH-1:0] value);
      write_fiq_mask(value);
      repeat (ITEMS_PER_MASK) send_item(random_item());
   endtask

   task automatic test_backpressure();
      req_tvalid <= 1'b0;
      hold_request = 1'b1;
      while (!hold_active) @(posedge clock);
      burst_left = 40;
      repeat (40) send_item(random_item());
   endtask

   // Receiver: stretches of steady, light or heavy stalling, plus the hold-off.
   initial begin
      int mode;
      int len;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active  = 1'b0;
            hold_request = 1'b0;
         end else begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(4, 40);
            repeat (len) begin
               case (mode)
                  0:       rsp_tready <= 1'b1;
                  1:       rsp_tready <= ($urandom_range(0, 3) != 0);
                  default: rsp_tready <= ($urandom_range(0, 3) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected response item: tdata=%h tuser=%b", rsp_tdata, rsp_tuser);
            failure_count++;
         end else begin
            exp_r = expected_results.pop_front();
            checked_count++;
            if (rsp_tdata[5:0] !== exp_r.read_data) begin
               $error("read_data: expected %0d, actual %0d", exp_r.read_data, rsp_tdata[5:0]);
               failure_count++;
            end
            if (rsp_tdata[6] !== exp_r.irq_out) begin
               $error("irq_out: expected %b, actual %b", exp_r.irq_out, rsp_tdata[6]);
               failure_count++;
            end
            if (rsp_tdata[7] !== exp_r.fiq_out) begin
               $error("fiq_out: expected %b, actual %b", exp_r.fiq_out, rsp_tdata[7]);
               failure_count++;
            end
            if (rsp_tuser !== exp_r.bad_access) begin
               $error("bad_access: expected %b, actual %b", exp_r.bad_access, rsp_tuser);
               failure_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      line_levels_now = '0;
      irq_enables_now = '0;
      fiq_mask_now    = '0;
      pending_now     = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_all_lines_pending();
      test_fiq_mask_phase(32'h0000_0000);
      test_fiq_mask_phase(32'hffff_ffff);
      test_fiq_mask_phase(32'h0000_0001);
      test_fiq_mask_phase(32'h8000_0000);
      test_fiq_mask_phase($urandom);
      test_fiq_mask_phase($urandom);
      test_backpressure();
      wait_drained();
      repeat (10) @(posedge clock);
      $display("Sent %0d items across %0d FIQ mask settings, %0d responses checked",
               sent_count, mask_settings, checked_count);
      $display("Peak pending count %0d, including one %0d-cycle receiver hold-off",
               peak_pending, HOLD_CYCLES);
      if (failure_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
